// ===== rtl/core/gbde_pkg.sv =====
// Package for the graph traversal engine: vertex widths, operation codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package gbde_pkg;

    localparam int VertexCount = 64;
    localparam int VertexWidth = 6;

    typedef logic [VertexWidth-1:0] vertex_t;
    typedef logic [VertexCount-1:0] row_t;

    typedef enum logic [2:0] {
        OP_ADD_EDGE = 3'd0,
        OP_TEST     = 3'd1,
        OP_LIST     = 3'd2,
        OP_TRAVERSE = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WA,
        ST_ADD_WB,
        ST_TEST,
        ST_LIST_LOAD,
        ST_LIST_SCAN,
        ST_TRAV_POP,
        ST_TRAV_READ,
        ST_TRAV_LOAD,
        ST_TRAV_SCAN,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic    load;        // capture the input beat
        logic    read_a;      // read row of first vertex
        logic    read_b;      // read row of second vertex
        logic    read_pop;    // read row of popped vertex
        logic    write_a;     // write read row with bit b set into row a
        logic    write_b;     // write read row with bit a set into row b
        logic    clear_step;  // zero one row, advance sweep
        logic    trav_init;   // reset store, push start vertex
        logic    pop;         // pop one vertex from the pending store
        logic    load_list;   // load scan row with the read row
        logic    load_trav;   // load scan row with the unvisited part of the read row
        logic    scan_list;   // emit next neighbour from the scan row
        logic    push_scan;   // push next fresh neighbour
        logic    set_test;    // form test result
        logic    set_none;    // form empty result
    } cmd_t;

    typedef struct packed {
        logic    op_valid;
        op_t     op;
        logic    scan_empty;
        logic    scan_last;
        logic    store_empty;
        logic    hit_stop;
        logic    clear_last;
    } stat_t;

endpackage

// ===== rtl/core/gbde_datapath.sv =====
// Datapath of the graph traversal engine: adjacency memory, visited marks,
// pending store and scan register. Depends on gbde_pkg.
module gbde_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gbde_pkg::cmd_t       cmd,
    output gbde_pkg::stat_t      stat,
    input  logic [2:0]           in_kind,
    input  gbde_pkg::vertex_t    in_a,
    input  gbde_pkg::vertex_t    in_b,
    input  logic [6:0]           in_stop,
    input  logic                 in_dfs,
    output gbde_pkg::vertex_t    res_vertex,
    output logic                 res_adj,
    output logic                 res_none
);
    import gbde_pkg::*;

    row_t    adj_mem [VertexCount];
    vertex_t pend_mem [VertexCount];
    row_t    rd_reg;
    row_t    visited_reg;
    row_t    scan_reg;
    logic [VertexWidth:0] head_reg, tail_reg;
    logic [2:0] kind_reg;
    vertex_t a_reg, b_reg;
    logic [6:0] stop_reg;
    logic dfs_reg;
    vertex_t clr_reg;
    vertex_t pend_rd_reg;
    vertex_t res_vertex_reg;
    logic res_adj_reg, res_none_reg;
    vertex_t low_idx;
    row_t low_bit;
    row_t scan_rest;
    logic [VertexWidth:0] tail_dec;
    vertex_t pop_addr;
    logic adj_we, adj_re;
    vertex_t adj_waddr, adj_raddr;
    row_t adj_wdata;
    logic pend_we;
    vertex_t pend_waddr, pend_wdata;

    // Lowest set bit of the scan row.
    always_comb begin
        low_idx = '0;
        for (int i = VertexCount - 1; i >= 0; i--) begin
            if (scan_reg[i]) low_idx = VertexWidth'(i);
        end
        low_bit = row_t'(1) << low_idx;
    end

    assign scan_rest = scan_reg & ~low_bit;
    assign tail_dec  = tail_reg - 1'b1;
    assign pop_addr  = dfs_reg ? tail_dec[VertexWidth-1:0] : head_reg[VertexWidth-1:0];

    // One write and one registered read of the adjacency memory per cycle.
    // An edge is added as read-modify-write of row a, then of row b.
    always_comb begin
        adj_we    = cmd.write_a | cmd.write_b | cmd.clear_step;
        adj_waddr = a_reg;
        adj_wdata = rd_reg | (row_t'(1) << b_reg);
        if (cmd.clear_step) begin
            adj_waddr = clr_reg;
            adj_wdata = '0;
        end else if (cmd.write_b) begin
            adj_waddr = b_reg;
            adj_wdata = rd_reg | (row_t'(1) << a_reg);
        end
        adj_re    = cmd.read_a | cmd.read_b | cmd.read_pop;
        adj_raddr = a_reg;
        if (cmd.read_pop) begin
            adj_raddr = pend_rd_reg;
        end else if (cmd.read_b) begin
            adj_raddr = b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
        if (adj_re) rd_reg <= adj_mem[adj_raddr];
    end

    // Pending store: one write and one registered read per cycle.
    assign pend_we    = cmd.trav_init | cmd.push_scan;
    assign pend_waddr = cmd.trav_init ? '0 : tail_reg[VertexWidth-1:0];
    assign pend_wdata = cmd.trav_init ? a_reg : low_idx;

    always_ff @(posedge aclk) begin
        if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
        if (cmd.pop) pend_rd_reg <= pend_mem[pop_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            a_reg    <= in_a;
            b_reg    <= in_b;
            stop_reg <= in_stop;
            dfs_reg  <= in_dfs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            clr_reg     <= '0;
        end else begin
            if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.trav_init) begin
                head_reg    <= '0;
                tail_reg    <= (VertexWidth+1)'(1);
                visited_reg <= row_t'(1) << a_reg;
            end else if (cmd.pop) begin
                if (dfs_reg) tail_reg <= tail_dec;
                else head_reg <= head_reg + 1'b1;
            end else if (cmd.push_scan) begin
                tail_reg    <= tail_reg + 1'b1;
                visited_reg <= visited_reg | low_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_list) begin
            scan_reg <= rd_reg;
        end else if (cmd.load_trav) begin
            scan_reg <= rd_reg & ~visited_reg;
        end else if (cmd.scan_list || cmd.push_scan) begin
            scan_reg <= scan_rest;
        end

        if (cmd.scan_list) begin
            res_vertex_reg <= low_idx;
            res_adj_reg    <= 1'b0;
            res_none_reg   <= 1'b0;
        end else if (cmd.set_test) begin
            res_vertex_reg <= '0;
            res_adj_reg    <= rd_reg[b_reg];
            res_none_reg   <= 1'b1;
        end else if (cmd.set_none) begin
            res_vertex_reg <= '0;
            res_adj_reg    <= 1'b0;
            res_none_reg   <= 1'b1;
        end else if (cmd.read_pop) begin
            res_vertex_reg <= pend_rd_reg;
            res_adj_reg    <= 1'b0;
            res_none_reg   <= 1'b0;
        end
    end

    assign stat.op_valid    = (kind_reg <= OP_CLEAR);
    assign stat.op          = op_t'(kind_reg);
    assign stat.scan_empty  = (scan_reg == '0);
    assign stat.scan_last   = (scan_rest == '0);
    assign stat.store_empty = (head_reg == tail_reg);
    assign stat.hit_stop    = ({1'b0, res_vertex_reg} == stop_reg);
    assign stat.clear_last  = (clr_reg == vertex_t'(VertexCount - 1));

    assign res_vertex = res_vertex_reg;
    assign res_adj    = res_adj_reg;
    assign res_none   = res_none_reg;

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> head_reg != tail_reg);
    a_push_has_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_scan |-> scan_reg != '0);
    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg - head_reg) <= 7'd64);
endmodule

// ===== rtl/core/gbde_controller.sv =====
// Controller state machine of the graph traversal engine. It sequences the
// datapath through commands and hands results to the output stage. Uses gbde_pkg.
module gbde_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbde_pkg::stat_t   stat,
    output gbde_pkg::cmd_t    cmd,
    output logic              res_valid,
    output logic              res_last,
    input  logic              res_ready
);
    import gbde_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   last_reg, last_next;

    // Reset enters the clearing sweep so the graph starts out empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (!stat.op_valid) begin
                    state_next = ST_IDLE;
                end else begin
                    unique case (stat.op)
                        OP_ADD_EDGE: state_next = ST_ADD_WA;
                        OP_TEST:     state_next = ST_TEST;
                        OP_LIST:     state_next = ST_LIST_LOAD;
                        OP_TRAVERSE: state_next = ST_TRAV_POP;
                        OP_CLEAR:    state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_WA: state_next = ST_ADD_WB;
            ST_ADD_WB: state_next = ST_IDLE;
            ST_TEST: begin
                state_next = ST_EMIT;
                ret_next   = ST_IDLE;
                last_next  = 1'b1;
            end
            ST_LIST_LOAD: state_next = ST_LIST_SCAN;
            ST_LIST_SCAN: begin
                state_next = ST_EMIT;
                if (stat.scan_empty || stat.scan_last) begin
                    ret_next  = ST_IDLE;
                    last_next = 1'b1;
                end else begin
                    ret_next  = ST_LIST_SCAN;
                    last_next = 1'b0;
                end
            end
            ST_TRAV_POP: state_next = ST_TRAV_READ;
            ST_TRAV_READ: state_next = ST_TRAV_LOAD;
            ST_TRAV_LOAD: begin
                if (stat.hit_stop) begin
                    state_next = ST_EMIT;
                    ret_next   = ST_IDLE;
                    last_next  = 1'b1;
                end else begin
                    state_next = ST_TRAV_SCAN;
                end
            end
            ST_TRAV_SCAN: begin
                if (stat.scan_empty) begin
                    state_next = ST_EMIT;
                    if (stat.store_empty) begin
                        ret_next  = ST_IDLE;
                        last_next = 1'b1;
                    end else begin
                        ret_next  = ST_TRAV_POP;
                        last_next = 1'b0;
                    end
                end
            end
            ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
            ST_EMIT: if (res_ready) state_next = ret_reg;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res_last  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE: begin
                if (stat.op_valid) begin
                    unique case (stat.op) inside
                        OP_ADD_EDGE, OP_TEST, OP_LIST: cmd.read_a = 1'b1;
                        OP_TRAVERSE: cmd.trav_init = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_ADD_WA: begin
                cmd.write_a = 1'b1;
                cmd.read_b  = 1'b1;
            end
            ST_ADD_WB: cmd.write_b = 1'b1;
            ST_TEST: cmd.set_test = 1'b1;
            ST_LIST_LOAD: cmd.load_list = 1'b1;
            ST_LIST_SCAN: begin
                if (stat.scan_empty) cmd.set_none = 1'b1;
                else cmd.scan_list = 1'b1;
            end
            ST_TRAV_POP: cmd.pop = 1'b1;
            ST_TRAV_READ: cmd.read_pop = 1'b1;
            ST_TRAV_LOAD: cmd.load_trav = !stat.hit_stop;
            ST_TRAV_SCAN: cmd.push_scan = !stat.scan_empty;
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_EMIT: res_valid = 1'b1;
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && res_valid));
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_last));
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready);
endmodule

// ===== rtl/core/graph_bfs_dfs_engine_top.sv =====
// Top level of the graph traversal engine: stream ports, controller and
// datapath. Depends on gbde_pkg, gbde_controller and gbde_datapath.
//
// One input beat carries one operation on an undirected 64-vertex graph kept
// as an adjacency bit matrix: add edge, test adjacency, list neighbours,
// traverse (breadth- or depth-first) and clear. Add edge, clear and unused
// kinds give no result beat; test gives one; list gives one beat per
// neighbour (or one empty beat) and traverse one per vertex popped from the
// pending store, with m_tlast on the final beat. Items are handled one at a
// time: s_tready is high only while the block is idle. Clear zeroes the
// adjacency memory one row per cycle. A list loads the row of the first
// vertex, then alternates between taking its next neighbour and emitting it.
// For each vertex a traversal pops the pending store, reads the row, loads
// the unvisited neighbours (skipped on the stop vertex), pushes them and then
// emits the vertex; the single adjacency read port and the bit-per-cycle scan
// set the pace of a traversal. Reset starts a sweep that empties the
// adjacency memory; s_tready stays low until it ends.
// When the receiver stalls, the pending result beat holds and the engine waits.
module graph_bfs_dfs_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // kind
    input  logic [23:0] s_tdata,   // first_vertex, second_vertex, stop_vertex, depth_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_vertex, is_adjacent, no_vertex
    output logic        m_tlast
);
    import gbde_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    vertex_t res_vertex;
    logic    res_adj, res_none;

    gbde_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .cmd(cmd),
        .res_valid(m_tvalid), .res_last(m_tlast), .res_ready(m_tready)
    );

    gbde_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .in_kind(s_tuser), .in_a(s_tdata[5:0]), .in_b(s_tdata[11:6]),
        .in_stop(s_tdata[18:12]), .in_dfs(s_tdata[19]),
        .res_vertex(res_vertex), .res_adj(res_adj), .res_none(res_none)
    );

    assign m_tdata = {res_none, res_adj, res_vertex};
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for graph_bfs_dfs_engine_top: a scoreboard class
// predicts every result beat from its own copy of the adjacency matrix.
// Depends on gbde_pkg and the graph_bfs_dfs_engine_top RTL.
`timescale 1ns / 100ps

module tb_top;
    import gbde_pkg::*;

    // Kind codes that the block has to ignore.
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    // Stop values that never match any vertex.
    localparam logic [6:0] NO_STOP     = 7'd64;
    localparam logic [6:0] NO_STOP_MAX = 7'd127;

    typedef struct packed {
        logic [5:0] vtx;
        logic       adj;
        logic       none;
        logic       last;
    } graph_beat_t;

    // Holds the predicted graph and the result beats still owed by the block.
    class graph_scoreboard;
        logic [63:0]  rows [64];
        graph_beat_t  owed_beats [$];
        int           failures;

        function new();
            foreach (rows[i]) rows[i] = '0;
            failures = 0;
        endfunction

        function void owe(logic [5:0] v, logic adj, logic none);
            graph_beat_t b;
            b.vtx  = v;
            b.adj  = adj;
            b.none = none;
            b.last = 1'b0;
            owed_beats.push_back(b);
        endfunction

        // Visit order: a vertex is marked when it enters the pending store.
        function void walk(logic [5:0] start, logic [6:0] stop, logic lifo);
            logic [5:0]  pending [$];
            logic [63:0] seen;
            logic [5:0]  u;
            int          emitted;
            seen = '0;
            emitted = 0;
            pending.push_back(start);
            seen[start] = 1'b1;
            while (pending.size() != 0 && emitted < 64) begin
                u = lifo ? pending.pop_back() : pending.pop_front();
                owe(u, 1'b0, 1'b0);
                emitted++;
                if ({1'b0, u} == stop) break;
                for (int v = 0; v < 64; v++) begin
                    if (rows[u][v] && !seen[v]) begin
                        seen[v] = 1'b1;
                        pending.push_back(v[5:0]);
                    end
                end
            end
        endfunction

        // Notes one accepted input beat and queues the beats it causes.
        function void note_input(logic [2:0] kind, logic [5:0] a, logic [5:0] b,
                                 logic [6:0] stop, logic lifo);
            int before_cnt;
            before_cnt = owed_beats.size();
            case (kind)
                OP_ADD_EDGE: begin
                    rows[a][b] = 1'b1;
                    rows[b][a] = 1'b1;
                end
                OP_TEST: owe(6'd0, rows[a][b], 1'b1);
                OP_LIST: begin
                    for (int v = 0; v < 64; v++)
                        if (rows[a][v]) owe(v[5:0], 1'b0, 1'b0);
                    if (owed_beats.size() == before_cnt) owe(6'd0, 1'b0, 1'b1);
                end
                OP_TRAVERSE: walk(a, stop, lifo);
                OP_CLEAR: foreach (rows[i]) rows[i] = '0;
                default: ;
            endcase
            if (owed_beats.size() != before_cnt)
                owed_beats[owed_beats.size()-1].last = 1'b1;
        endfunction

        function void check_result(logic [7:0] data, logic last);
            graph_beat_t e;
            if (owed_beats.size() == 0) begin
                $error("unexpected result beat: data=%h last=%b", data, last);
                failures++;
                return;
            end
            e = owed_beats.pop_front();
            if (data[5:0] !== e.vtx) begin
                $error("out_vertex: expected %0d, actual %0d", e.vtx, data[5:0]);
                failures++;
            end
            if (data[6] !== e.adj) begin
                $error("is_adjacent: expected %0b, actual %0b", e.adj, data[6]);
                failures++;
            end
            if (data[7] !== e.none) begin
                $error("no_vertex: expected %0b, actual %0b", e.none, data[7]);
                failures++;
            end
            if (last !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, last);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;   // kind
    logic [23:0] s_tdata;   // first_vertex, second_vertex, stop_vertex, depth_first
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_vertex, is_adjacent, no_vertex
    logic        m_tlast;

    graph_scoreboard sb;
    // While set, neither side inserts idle cycles.
    logic steady_flow;

    graph_bfs_dfs_engine_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls in about a third of the cycles, except in the
    // steady stretch. It changes only on the falling edge.
    always @(negedge aclk) begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // Result beats are sampled on the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    // Presents one operation and holds it until the block takes the beat.
    // Each call starts on a fresh falling edge, so s_tvalid is assigned at
    // most once per time step.
    task automatic send_op(logic [2:0] kind, logic [5:0] a, logic [5:0] b,
                           logic [6:0] stop, logic lifo);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, lifo, stop, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, a, b, stop, lifo);
    endtask

    // One random operation. Edges mostly land in a small vertex pool so that
    // traversals reach long, branching paths instead of isolated vertices.
    task automatic random_op();
        int         pick;
        logic [5:0] a;
        logic [5:0] b;
        logic [6:0] stop;
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0) begin
            a = 6'($urandom_range(63));
            b = 6'($urandom_range(63));
        end else begin
            a = 6'($urandom_range(15));
            b = 6'($urandom_range(15));
        end
        stop = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(15));
        if (pick < 42)
            send_op(OP_ADD_EDGE, a, b, stop, 1'($urandom_range(1)));
        else if (pick < 52)
            send_op(OP_TEST, a, b, stop, 1'($urandom_range(1)));
        else if (pick < 64)
            send_op(OP_LIST, a, b, stop, 1'($urandom_range(1)));
        else if (pick < 91)
            send_op(OP_TRAVERSE, a, b, stop, 1'($urandom_range(1)));
        else if (pick < 95)
            send_op(OP_CLEAR, a, b, stop, 1'($urandom_range(1)));
        else
            send_op(3'($urandom_range(7, 5)), a, b, stop, 1'($urandom_range(1)));
    endtask

    initial begin
        sb          = new();
        steady_flow = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the empty graph that reset leaves:
        // extreme vertices, a self-loop, a repeated edge, empty lists, early
        // stops and every kind including the spare ones.
        send_op(OP_LIST, 6'd5, 6'd0, NO_STOP, 1'b0);
        send_op(OP_ADD_EDGE, 6'd0, 6'd63, NO_STOP, 1'b0);
        send_op(OP_ADD_EDGE, 6'd63, 6'd63, NO_STOP, 1'b1);
        send_op(OP_ADD_EDGE, 6'd0, 6'd1, NO_STOP, 1'b0);
        send_op(OP_ADD_EDGE, 6'd1, 6'd0, NO_STOP, 1'b0);
        send_op(OP_ADD_EDGE, 6'd1, 6'd2, NO_STOP, 1'b0);
        send_op(OP_ADD_EDGE, 6'd2, 6'd63, NO_STOP, 1'b0);
        send_op(OP_TEST, 6'd63, 6'd0, NO_STOP, 1'b0);
        send_op(OP_TEST, 6'd42, 6'd21, NO_STOP, 1'b0);
        send_op(OP_LIST, 6'd63, 6'd0, NO_STOP, 1'b0);
        send_op(OP_LIST, 6'd40, 6'd0, NO_STOP, 1'b0);
        send_op(OP_TRAVERSE, 6'd0, 6'd63, NO_STOP_MAX, 1'b0);
        send_op(OP_TRAVERSE, 6'd0, 6'd0, NO_STOP, 1'b1);
        send_op(OP_TRAVERSE, 6'd0, 6'd0, 7'd2, 1'b0);
        send_op(OP_TRAVERSE, 6'd63, 6'd0, 7'd0, 1'b1);
        send_op(OP_TRAVERSE, 6'd40, 6'd0, 7'd40, 1'b0);
        send_op(KIND_SPARE_5, 6'd63, 6'd63, NO_STOP_MAX, 1'b1);
        send_op(KIND_SPARE_6, 6'd1, 6'd2, NO_STOP, 1'b0);
        send_op(KIND_SPARE_7, 6'd2, 6'd1, NO_STOP, 1'b1);
        send_op(OP_CLEAR, 6'd63, 6'd63, NO_STOP_MAX, 1'b1);
        send_op(OP_LIST, 6'd0, 6'd0, NO_STOP, 1'b0);
        send_op(OP_TRAVERSE, 6'd63, 6'd0, NO_STOP, 1'b0);

        // Random part, with a stretch in the middle where nobody idles.
        for (int i = 0; i < 420; i++) begin
            steady_flow = (i >= 150 && i < 230);
            random_op();
        end
        steady_flow = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.owed_beats.size() != 0) @(posedge aclk);
        // Room for a stray beat from a misbehaving block to show up.
        repeat (300) @(posedge aclk);

        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gbde_pkg.sv
rtl/core/gbde_datapath.sv
rtl/core/gbde_controller.sv
rtl/core/graph_bfs_dfs_engine_top.sv
sim/tb_top.sv
